FILE: sv/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 byte stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  typedef enum logic [2:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_NONCE_L = 3'd4,
    REG_NONCE_H = 3'd5,
    REG_START   = 3'd6
  } reg_idx_t;

  typedef logic [15:0][31:0] word_arr_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } q_item_t;

  // back end -> keystream core
  typedef struct packed {
    logic        start;
    logic [31:0] counter;
  } gen_req_t;

  // keystream core -> back end
  typedef struct packed {
    logic done;
  } gen_stat_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // One line of a quarter round; line selects which of the four add/xor/rotate steps.
  function automatic quad_t qr_line(input logic [1:0] line, input quad_t q);
    quad_t r;
    logic [31:0] t;
    r = q;
    t = '0;
    case (line)
      2'd0: begin
        r.a = q.a + q.b;
        t   = q.d ^ r.a;
        r.d = {t[15:0], t[31:16]};
      end
      2'd1: begin
        r.c = q.c + q.d;
        t   = q.b ^ r.c;
        r.b = {t[19:0], t[31:20]};
      end
      2'd2: begin
        r.a = q.a + q.b;
        t   = q.d ^ r.a;
        r.d = {t[23:0], t[31:24]};
      end
      default: begin
        r.c = q.c + q.d;
        t   = q.b ^ r.c;
        r.b = {t[24:0], t[31:25]};
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cc20_front.sv
// ----------------------------------------------------------------------------
// cc20_front
// Input side: accepts message bytes and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_front
  import cc20_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,
  output logic            head_valid,
  output q_item_t         head,
  input  wire logic       pop
);

  q_item_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              do_pop;

  assign s_tready   = (count != (QPTR_W+1)'(QDEPTH));
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{data: s_tdata, last: s_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Keystream block generator: one quarter-round line on all four lanes a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_core
  import cc20_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire gen_req_t req,
  output gen_stat_t     stat,
  output word_arr_t     ks
);

  localparam int unsigned DR_W = $clog2(DOUBLE_ROUNDS);

  typedef enum logic [1:0] {
    IDLE,
    ROUND,
    ADD
  } state_t;

  state_t          state;
  logic [2:0]      step;     // [1:0] line, [2] diagonal pass
  logic [DR_W-1:0] dround;
  logic            done;
  word_arr_t       work;
  word_arr_t       work_next;
  word_arr_t       init;
  word_arr_t       init_next;

  always_comb begin
    init_next[0]  = SIGMA0;
    init_next[1]  = SIGMA1;
    init_next[2]  = SIGMA2;
    init_next[3]  = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_next[4 + 2*i] = cfg.key[i][31:0];
      init_next[5 + 2*i] = cfg.key[i][63:32];
    end
    init_next[12] = req.counter;
    init_next[13] = cfg.nonce_low[31:0];
    init_next[14] = cfg.nonce_low[63:32];
    init_next[15] = cfg.nonce_high;
  end

  // Four lanes touch disjoint words, so they update side by side.
  always_comb begin
    logic [1:0] la, lb, lc, ld;
    quad_t      qi, qo;
    work_next = work;
    for (int q = 0; q < 4; q++) begin
      la = 2'(q);
      lb = la + {1'b0, step[2]};
      lc = la + (step[2] ? 2'd2 : 2'd0);
      ld = la + (step[2] ? 2'd3 : 2'd0);
      qi = '{a: work[{2'b00, la}], b: work[{2'b01, lb}],
             c: work[{2'b10, lc}], d: work[{2'b11, ld}]};
      qo = qr_line(step[1:0], qi);
      work_next[{2'b00, la}] = qo.a;
      work_next[{2'b01, lb}] = qo.b;
      work_next[{2'b10, lc}] = qo.c;
      work_next[{2'b11, ld}] = qo.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      step   <= '0;
      dround <= '0;
      done   <= 1'b0;
    end else begin
      done <= (state == ADD);
      unique case (state)
        IDLE: begin
          if (req.start) begin
            step   <= '0;
            dround <= '0;
            state  <= ROUND;
          end
        end
        ROUND: begin
          step <= step + 1'b1;
          if (step == 3'd7) begin
            if (dround == DR_W'(DOUBLE_ROUNDS - 1)) begin
              state <= ADD;
            end else begin
              dround <= dround + 1'b1;
            end
          end
        end
        ADD: begin
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == IDLE && req.start) begin
      init <= init_next;
      work <= init_next;
    end else if (state == ROUND) begin
      work <= work_next;
    end else if (state == ADD) begin
      for (int i = 0; i < 16; i++) begin
        work[i] <= work[i] + init[i];
      end
    end
  end

  assign stat.done = done;
  assign ks        = work;

endmodule

`default_nettype wire

FILE: sv/cc20_back.sv
// ----------------------------------------------------------------------------
// cc20_back
// Back end: tracks message and block position, requests blocks, XORs bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_back
  import cc20_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] start_counter,
  input  wire logic        head_valid,
  input  wire q_item_t     head,
  output logic             pop,
  output gen_req_t         req,
  input  wire gen_stat_t   stat,
  input  wire word_arr_t   ks,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] result_byte
  output logic             m_tlast
);

  typedef enum logic {
    RUN,
    WAIT
  } state_t;

  state_t      state;
  logic        in_msg;
  logic        ks_valid;
  logic [5:0]  pos;
  logic [31:0] blk_cnt;
  logic        out_free;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == RUN) && head_valid && in_msg && ks_valid && out_free;
  assign ks_word  = ks[pos[5:2]];
  assign ks_byte  = ks_word[{pos[1:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RUN;
      in_msg    <= 1'b0;
      ks_valid  <= 1'b0;
      pos       <= '0;
      blk_cnt   <= '0;
      req.start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // block needed at message start or once the current one is used up
      req.start <= (state == RUN) && head_valid && (!in_msg || !ks_valid);
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        RUN: begin
          if (head_valid && !in_msg) begin
            in_msg      <= 1'b1;
            pos         <= '0;
            blk_cnt     <= start_counter;
            req.counter <= start_counter;
            state       <= WAIT;
          end else if (head_valid && !ks_valid) begin
            req.counter <= blk_cnt;
            state       <= WAIT;
          end else if (pop) begin
            m_tdata  <= head.data ^ ks_byte;
            m_tlast  <= head.last;
            pos      <= pos + 1'b1;
            if (pos == 6'd63) begin
              blk_cnt <= blk_cnt + 1'b1;
            end
            if (pos == 6'd63 || head.last) begin
              ks_valid <= 1'b0;
            end
            if (head.last) begin
              in_msg <= 1'b0;
            end
          end
        end
        WAIT: begin
          if (stat.done) begin
            ks_valid <= 1'b1;
            state    <= RUN;
          end
        end
        default: state <= RUN;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 byte stream cipher with key, nonce and start counter registers.
// ----------------------------------------------------------------------------
// Each input byte is XORed with the next ChaCha20 keystream byte (RFC 8439
// layout), so the block both encrypts and decrypts. The first byte of a
// message loads the block counter from start_counter; tlast closes the
// message. Within a 64-byte block one byte is taken per cycle while the
// output is not stalled. At the start of a message and at every 64-byte
// boundary the byte waits for the next keystream block: the shared
// quarter-round unit runs one line on all four lanes per cycle through the
// column and diagonal passes of DOUBLE_ROUNDS double rounds, then the final
// add. Input bytes keep queuing in a four-entry queue meanwhile.
// Configuration writes are always accepted and belong in idle periods.
`default_nettype none

module chacha20_stream_cipher
  import cc20_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // [7:0] result_byte
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cfg_t        cfg;
  logic [31:0] start_counter;
  logic        head_valid;
  q_item_t     head;
  logic        pop;
  gen_req_t    req;
  gen_stat_t   stat;
  word_arr_t   ks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg           <= '0;
      start_counter <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY0:    cfg.key[0]     <= cfg_data;
        REG_KEY1:    cfg.key[1]     <= cfg_data;
        REG_KEY2:    cfg.key[2]     <= cfg_data;
        REG_KEY3:    cfg.key[3]     <= cfg_data;
        REG_NONCE_L: cfg.nonce_low  <= cfg_data;
        REG_NONCE_H: cfg.nonce_high <= cfg_data[31:0];
        REG_START:   start_counter  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .req  (req),
    .stat (stat),
    .ks   (ks)
  );

  cc20_back u_back (
    .clk           (clk),
    .rst           (rst),
    .start_counter (start_counter),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .req           (req),
    .stat          (stat),
    .ks            (ks),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

endmodule

`default_nettype wire
